>>> design/mdht_pkg.sv
package mdht_pkg;

    localparam int BUCKET_COUNT = 4096;
    localparam int BUCKET_W     = $clog2(BUCKET_COUNT);
    localparam int SLOT_W       = 12;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    // FNV prime 16777619 is 2^24 + 0x193.
    localparam logic [8:0]  FNV_PRIME_LO = 9'h193;

    localparam logic [15:0] CAP_RESET = 16'd2048;

    localparam int S_TDATA_W = 184;
    localparam int M_TDATA_W = 80;

    localparam logic [2:0] ST_NEW       = 3'd0;
    localparam logic [2:0] ST_STRONGER  = 3'd1;
    localparam logic [2:0] ST_WEAKER    = 3'd2;
    localparam logic [2:0] ST_ROLLOVER  = 3'd3;
    localparam logic [2:0] ST_DROPPED   = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [47:0] address;
        logic [7:0]  best_signal;
        logic [7:0]  channel;
        logic        kind;
        logic [31:0] latitude;
        logic [31:0] longitude;
        logic [20:0] altitude;
        logic [31:0] seen_at;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [47:0] address;
        logic [7:0]  signal;
        logic [7:0]  channel;
        logic        kind;
        logic        pos_ok;
        logic [30:0] latitude;
        logic [31:0] longitude;
        logic        alt_ok;
        logic [20:0] altitude;
        logic [31:0] seen;
    } t_item;

endpackage

>>> design/mdht_ram.sv
module mdht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/mdht_fnv.sv
module mdht_fnv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_addr,
    output logic        o_done,
    output logic [31:0] o_hash
);
    import mdht_pkg::*;

    logic        r_busy;
    logic [2:0]  r_cnt;
    logic [47:0] r_addr;
    logic [31:0] r_h;
    logic        r_done;
    logic [31:0] x;
    logic [31:0] n_h;

    // One byte per cycle: xor, then multiply by the prime as a shift plus a small product.
    assign x   = r_h ^ {24'd0, r_addr[7:0]};
    assign n_h = (x << 24) + 32'(x * {23'd0, FNV_PRIME_LO});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h    <= FNV_BASIS;
            r_addr <= i_addr;
        end else if (r_busy) begin
            r_h    <= n_h;
            r_addr <= {8'd0, r_addr[47:8]};
        end
    end

    assign o_done = r_done;
    assign o_hash = r_h;

endmodule

>>> design/mac_dedup_hash_table.sv
// Flow: the address is hashed byte by byte, each bucket probed is read and then checked, then
// the entry is written and the result registered; a weaker sighting skips the write and a drop
// goes straight to the result. Only one beat is in flight: the next beat is taken once the
// result register has loaded. A rollover adds a clear of every bucket before the write.
// Reset is synchronous, active low; after reset the block sweeps the table, clearing every
// bucket, with o_s_tready low, while configuration writes are taken as usual.
module mac_dedup_hash_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // device_address[47:0], signal_dbm[55:48], radio_channel[63:56], position_valid[64],
    // latitude_e7[95:65], longitude_e7[127:96], altitude_valid[128], altitude_dm[149:129],
    // seen_time[181:150], zero pad[183:182]
    input  logic [mdht_pkg::S_TDATA_W-1:0] i_s_tdata,
    // is_ble[0]
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // slot_index[11:0], wifi_total[43:12], ble_total[75:44], zero pad[79:76]
    output logic [mdht_pkg::M_TDATA_W-1:0] o_m_tdata,
    // status[2:0]
    output logic [2:0]  o_m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mdht_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [1:0] REG_WIFI_EN = 2'd0;
    localparam logic [1:0] REG_BLE_EN  = 2'd1;
    localparam logic [1:0] REG_CAP     = 2'd2;

    localparam logic [BUCKET_W-1:0] LAST_BUCKET = BUCKET_W'(BUCKET_COUNT - 1);

    logic [2:0]          r_state;
    logic                r_wifi_en, r_ble_en;
    logic [15:0]         r_cap;
    logic [15:0]         r_sess_wifi, r_sess_ble;
    logic [31:0]         r_arch_wifi, r_arch_ble;
    logic [BUCKET_W-1:0] r_clr, r_slot, r_start, r_probe;
    logic                r_roll, r_ins;
    logic [2:0]          r_status;
    t_item               r_item;
    t_entry              r_wdata;
    logic                r_out_valid;
    logic [2:0]          r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [31:0]         r_out_wifi, r_out_ble;

    t_item               in_item;
    t_entry              rd_entry, ins_entry, upd_entry;
    logic [ENTRY_W-1:0]  ram_rdata, ram_wdata;
    logic [BUCKET_W-1:0] ram_addr;
    logic                ram_we;
    logic                hash_done;
    logic [31:0]         hash;
    logic                accept, kind_on, cfg_wr, out_free;
    logic [16:0]         sess_sum;

    assign in_item.address   = i_s_tdata[47:0];
    assign in_item.signal    = i_s_tdata[55:48];
    assign in_item.channel   = i_s_tdata[63:56];
    assign in_item.kind      = i_s_tuser;
    assign in_item.pos_ok    = i_s_tdata[64];
    assign in_item.latitude  = i_s_tdata[95:65];
    assign in_item.longitude = i_s_tdata[127:96];
    assign in_item.alt_ok    = i_s_tdata[128];
    assign in_item.altitude  = i_s_tdata[149:129];
    assign in_item.seen      = i_s_tdata[181:150];

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign kind_on    = i_s_tuser ? r_ble_en : r_wifi_en;
    assign out_free   = !r_out_valid || i_m_tready;

    // Configuration port: zero wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_WIFI_EN: prdata = {31'd0, r_wifi_en};
            REG_BLE_EN:  prdata = {31'd0, r_ble_en};
            REG_CAP:     prdata = {16'd0, r_cap};
            default:     prdata = 32'd0;
        endcase
    end

    mdht_fnv u_fnv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && kind_on),
        .i_addr  (in_item.address),
        .o_done  (hash_done),
        .o_hash  (hash)
    );

    // The table port is shared by the clearing sweep, the probes and the final write.
    always_comb begin
        unique case (r_state)
            S_CLEAR: ram_addr = r_clr;
            default: ram_addr = r_slot;
        endcase
    end
    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_WR);
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : r_wdata;

    mdht_ram #(.WIDTH(ENTRY_W), .DEPTH(BUCKET_COUNT)) u_table (
        .i_clk   (i_clk),
        .i_addr  (ram_addr),
        .i_we    (ram_we),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);

    // A fresh entry: position parts that are not valid are stored as zero.
    always_comb begin
        ins_entry.valid       = 1'b1;
        ins_entry.address     = r_item.address;
        ins_entry.best_signal = r_item.signal;
        ins_entry.channel     = r_item.channel;
        ins_entry.kind        = r_item.kind;
        ins_entry.latitude    = r_item.pos_ok ? {r_item.latitude[30], r_item.latitude} : 32'd0;
        ins_entry.longitude   = r_item.pos_ok ? r_item.longitude : 32'd0;
        ins_entry.altitude    = r_item.alt_ok ? r_item.altitude : 21'd0;
        ins_entry.seen_at     = r_item.seen;
    end

    // A known device keeps channel, kind and first-seen time.
    always_comb begin
        upd_entry             = rd_entry;
        upd_entry.best_signal = r_item.signal;
        if (r_item.pos_ok) begin
            upd_entry.latitude  = {r_item.latitude[30], r_item.latitude};
            upd_entry.longitude = r_item.longitude;
        end
        if (r_item.alt_ok) begin
            upd_entry.altitude = r_item.altitude;
        end
    end

    assign sess_sum = {1'b0, r_sess_wifi} + {1'b0, r_sess_ble};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_roll      <= 1'b0;
            r_ins       <= 1'b0;
            r_wifi_en   <= 1'b1;
            r_ble_en    <= 1'b1;
            r_cap       <= CAP_RESET;
            r_sess_wifi <= 16'd0;
            r_sess_ble  <= 16'd0;
            r_arch_wifi <= 32'd0;
            r_arch_ble  <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_WIFI_EN: r_wifi_en <= pwdata[0];
                    REG_BLE_EN:  r_ble_en  <= pwdata[0];
                    REG_CAP:     r_cap     <= pwdata[15:0];
                    default:     ;
                endcase
            end

            // The result register loads when a beat finishes and empties when taken.
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BUCKET_W'(1);
                    if (r_clr == LAST_BUCKET) begin
                        r_state <= r_roll ? S_WR : S_IDLE;
                        r_roll  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_ins <= 1'b0;
                        if (kind_on) begin
                            r_state <= S_HASH;
                        end else begin
                            r_status <= ST_DROPPED;
                            r_slot   <= '0;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        r_slot  <= hash[BUCKET_W-1:0];
                        r_start <= hash[BUCKET_W-1:0];
                        r_probe <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    priority if (rd_entry.valid && rd_entry.address == r_item.address) begin
                        if ($signed(r_item.signal) > $signed(rd_entry.best_signal)) begin
                            r_wdata  <= upd_entry;
                            r_status <= ST_STRONGER;
                            r_state  <= S_WR;
                        end else begin
                            r_status <= ST_WEAKER;
                            r_state  <= S_DONE;
                        end
                    end else if (!rd_entry.valid && sess_sum < {1'b0, r_cap}) begin
                        r_wdata  <= ins_entry;
                        r_ins    <= 1'b1;
                        r_status <= ST_NEW;
                        r_state  <= S_WR;
                    end else if (!rd_entry.valid || r_probe == LAST_BUCKET) begin
                        // Session full, or the table is full without a match: roll over.
                        r_arch_wifi <= r_arch_wifi + {16'd0, r_sess_wifi};
                        r_arch_ble  <= r_arch_ble + {16'd0, r_sess_ble};
                        r_sess_wifi <= 16'd0;
                        r_sess_ble  <= 16'd0;
                        r_wdata     <= ins_entry;
                        r_ins       <= 1'b1;
                        r_status    <= ST_ROLLOVER;
                        r_slot      <= r_start;
                        r_roll      <= 1'b1;
                        r_clr       <= '0;
                        r_state     <= S_CLEAR;
                    end else begin
                        r_slot  <= r_slot + BUCKET_W'(1);
                        r_probe <= r_probe + BUCKET_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_WR: begin
                    if (r_ins) begin
                        if (r_item.kind) begin
                            r_sess_ble <= r_sess_ble + 16'd1;
                        end else begin
                            r_sess_wifi <= r_sess_wifi + 16'd1;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= in_item;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_status;
            r_out_slot   <= SLOT_W'(r_slot);
            r_out_wifi   <= r_arch_wifi + {16'd0, r_sess_wifi};
            r_out_ble    <= r_arch_ble + {16'd0, r_sess_ble};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {4'd0, r_out_ble, r_out_wifi, r_out_slot};

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_HASH || r_state == S_DONE))
        else $error("accepted beat did not start hashing or finish as dropped");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("table written while idle");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == S_DONE))
        else $error("result shown without finishing a beat");
`endif

endmodule

>>> tb/mdht_checker.sv
package mdht_tb_pkg;

    // Byte addresses of the configuration registers.
    localparam logic [3:0] REG_WIFI_EN = 4'd0;
    localparam logic [3:0] REG_BLE_EN  = 4'd4;
    localparam logic [3:0] REG_CAP     = 4'd8;

    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;

    function automatic logic [11:0] bucket_of(input logic [47:0] mac);
        logic [31:0] h;
        h = HASH_BASIS;
        for (int b = 0; b < 6; b++) begin
            h = (h ^ {24'd0, mac[8*b +: 8]}) * HASH_PRIME;
        end
        return h[11:0];
    endfunction

endpackage

module mdht_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [183:0] i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [79:0]  i_m_tdata,
    input  logic [2:0]   i_m_tuser,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic         i_pready,
    input  logic [3:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_checked,
    output int           o_rollovers
);
    import mdht_pkg::*;
    import mdht_tb_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] slot;
        logic [31:0] wifi_total;
        logic [31:0] ble_total;
    } t_sighting_result;

    logic               slot_used [4096];
    logic [47:0]        slot_mac [4096];
    logic signed [7:0]  slot_rssi [4096];
    logic [15:0]        sess_wifi, sess_ble;
    logic [31:0]        arch_wifi, arch_ble;
    logic               wifi_on, ble_on;
    logic [15:0]        cap;
    t_sighting_result   awaited [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_rollovers  = 0;
    end

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("mismatch on result %0d: %s expected %0d got %0d", o_checked, what, want, got);
        o_fail_count++;
    endtask

    function automatic void clear_table();
        for (int k = 0; k < 4096; k++) slot_used[k] = 1'b0;
    endfunction

    // Looks the sighting up, updates the table and returns the result it produces.
    function automatic t_sighting_result classify_sighting(input logic [183:0] d,
                                                           input logic ble);
        t_sighting_result  r;
        logic [47:0]       mac;
        logic signed [7:0] rssi;
        logic [11:0]       start, s;
        logic              found, empty;
        mac   = d[47:0];
        rssi  = d[55:48];
        r.status = ST_DROPPED;
        r.slot   = '0;
        if (ble ? ble_on : wifi_on) begin
            start = bucket_of(mac);
            found = 1'b0;
            empty = 1'b0;
            s     = start;
            for (int k = 0; k < 4096; k++) begin
                s = start + k[11:0];
                if (!slot_used[s]) begin
                    empty = 1'b1;
                    break;
                end
                if (slot_mac[s] == mac) begin
                    found = 1'b1;
                    break;
                end
            end
            if (found) begin
                if (rssi > slot_rssi[s]) begin
                    slot_rssi[s] = rssi;
                    r.status = ST_STRONGER;
                end else begin
                    r.status = ST_WEAKER;
                end
            end else begin
                r.status = ST_NEW;
                if (!empty || ({1'b0, sess_wifi} + {1'b0, sess_ble}) >= {1'b0, cap}) begin
                    arch_wifi += sess_wifi;
                    arch_ble  += sess_ble;
                    sess_wifi = '0;
                    sess_ble  = '0;
                    clear_table();
                    s = start;
                    r.status = ST_ROLLOVER;
                end
                slot_used[s] = 1'b1;
                slot_mac[s]  = mac;
                slot_rssi[s] = rssi;
                if (ble) sess_ble++;
                else sess_wifi++;
            end
            r.slot = s;
        end
        r.wifi_total = arch_wifi + sess_wifi;
        r.ble_total  = arch_ble + sess_ble;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sighting_result want;
        if (!i_rst_n) begin
            clear_table();
            sess_wifi = '0;
            sess_ble  = '0;
            arch_wifi = '0;
            arch_ble  = '0;
            wifi_on   = 1'b1;
            ble_on    = 1'b1;
            cap       = CAP_RESET;
            awaited.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    REG_WIFI_EN: wifi_on = i_pwdata[0];
                    REG_BLE_EN:  ble_on  = i_pwdata[0];
                    REG_CAP:     cap     = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited.push_back(classify_sighting(i_s_tdata, i_s_tuser));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (awaited.size() == 0) begin
                    report("unexpected beat, status", 32'd0, {29'd0, i_m_tuser});
                end else begin
                    want = awaited.pop_front();
                    if (want.status == ST_ROLLOVER) o_rollovers++;
                    if (i_m_tuser !== want.status)
                        report("status", want.status, i_m_tuser);
                    if (i_m_tdata[11:0] !== want.slot)
                        report("slot_index", want.slot, i_m_tdata[11:0]);
                    if (i_m_tdata[43:12] !== want.wifi_total)
                        report("wifi_total", want.wifi_total, i_m_tdata[43:12]);
                    if (i_m_tdata[75:44] !== want.ble_total)
                        report("ble_total", want.ble_total, i_m_tdata[75:44]);
                end
                o_checked++;
            end
        end
        o_pending = awaited.size();
    end

endmodule

>>> tb/mac_dedup_hash_table_tb.sv
module mac_dedup_hash_table_tb;
    import mdht_pkg::*;
    import mdht_tb_pkg::*;

    localparam int CYCLE_LIMIT = 12000000;

    // One radio sighting as the stimulus side sees it.
    typedef struct {
        logic [47:0] mac;
        logic [7:0]  rssi;
        logic [7:0]  chan;
        logic        ble;
        logic        pos_ok;
        logic [30:0] lat;
        logic [31:0] lon;
        logic        alt_ok;
        logic [20:0] alt;
        logic [31:0] seen;
    } t_sighting;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [183:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count, pending, checked, rollovers;
    int cycles = 0;
    // When set, neither side inserts idle cycles between beats.
    logic back_to_back = 1'b0;
    logic [47:0] device_pool [64];

    always #5 i_clk = ~i_clk;

    mac_dedup_hash_table i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    mdht_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_rollovers  (rollovers)
    );

    // Watchdog: the slowest legal run is far below this many cycles.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("** mac_dedup_hash_table: FAILED **");
            $finish;
        end
    end

    function automatic int idle_cycles();
        return back_to_back ? 0 : $urandom_range(0, 12);
    endfunction

    // Result side: stalls a random number of cycles before taking each beat.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = idle_cycles();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    // Two-phase register write; called and returns at a falling edge.
    task automatic write_reg(input logic [3:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stops sending, drains all outstanding results, lets a dropped beat settle, then
    // reprograms.
    task automatic reconfigure(input logic wifi_on, input logic ble_on, input logic [15:0] cap);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        write_reg(REG_WIFI_EN, {31'd0, wifi_on});
        write_reg(REG_BLE_EN, {31'd0, ble_on});
        write_reg(REG_CAP, {16'd0, cap});
    endtask

    // Presents one sighting; the valid stays high if the next beat follows with no gap.
    task automatic send_sighting(input t_sighting it);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.ble;
        s_tdata  <= {2'b00, it.seen, it.alt, it.alt_ok, it.lon, it.lat, it.pos_ok,
                     it.chan, it.rssi, it.mac};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    function automatic t_sighting random_sighting();
        t_sighting it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) it.mac = device_pool[$urandom_range(0, 63)];
        else if (pick < 95) it.mac = 48'({$urandom, $urandom});
        else it.mac = pick[0] ? 48'hFFFF_FFFF_FFFF : 48'h0;
        it.rssi   = 8'($urandom);
        it.chan   = 8'($urandom);
        it.ble    = 1'($urandom);
        it.pos_ok = 1'($urandom);
        it.lat    = 31'($urandom);
        it.lon    = $urandom;
        it.alt_ok = 1'($urandom);
        it.alt    = 21'($urandom);
        it.seen   = $urandom;
        return it;
    endfunction

    task automatic random_phase(input int count);
        repeat (count) send_sighting(random_sighting());
    endtask

    // Fills the pool: two groups share a home bucket each, so that probing goes past the first
    // bucket, and the rest are random. One group sits on the last bucket to force wraparound.
    task automatic build_device_pool();
        logic [47:0] cand;
        logic [11:0] home;
        for (int g = 0; g < 2; g++) begin
            home = (g == 0) ? 12'hFFF : 12'($urandom);
            for (int k = 0; k < 5; k++) begin
                do cand = 48'({$urandom, $urandom}); while (bucket_of(cand) != home);
                device_pool[g * 5 + k] = cand;
            end
        end
        for (int k = 10; k < 64; k++) device_pool[k] = 48'({$urandom, $urandom});
    endtask

    initial begin
        t_sighting it;
        build_device_pool();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sightings under the reset configuration: address and field
        // extremes, a known device getting stronger, equal and weaker, partial
        // position fixes, and a collision chain wrapping past the last bucket.
        it = '{mac: 48'h0, rssi: 8'h80, chan: 8'h00, ble: 1'b0, pos_ok: 1'b0,
               lat: 31'h4000_0000, lon: 32'h8000_0000, alt_ok: 1'b0, alt: 21'h10_0000,
               seen: 32'h0};
        send_sighting(it);
        it.rssi = 8'h7F; it.pos_ok = 1'b1; it.alt_ok = 1'b1;
        send_sighting(it);
        send_sighting(it);
        it.rssi = 8'h00; it.lat = 31'h3FFF_FFFF; it.lon = 32'h7FFF_FFFF;
        send_sighting(it);
        it = '{mac: 48'hFFFF_FFFF_FFFF, rssi: 8'h7F, chan: 8'hFF, ble: 1'b1, pos_ok: 1'b1,
               lat: 31'h3FFF_FFFF, lon: 32'h7FFF_FFFF, alt_ok: 1'b1, alt: 21'h0F_FFFF,
               seen: 32'hFFFF_FFFF};
        send_sighting(it);
        it.rssi = 8'h80;
        send_sighting(it);
        for (int k = 0; k < 5; k++) begin
            it.mac = device_pool[k];
            it.ble = k[0];
            it.pos_ok = k[1];
            it.alt_ok = ~k[1];
            it.rssi = 8'hF0;
            send_sighting(it);
        end
        for (int k = 4; k >= 0; k--) begin
            it.mac = device_pool[k];
            it.rssi = (k % 2 == 0) ? 8'hF8 : 8'hE0;
            send_sighting(it);
        end
        for (int k = 5; k < 8; k++) begin
            it = random_sighting();
            it.mac = device_pool[k];
            send_sighting(it);
        end

        // Full cap, both kinds enabled.
        reconfigure(1'b1, 1'b1, 16'hFFFF);
        random_phase(150);

        // WiFi dropped, small sessions roll over often.
        reconfigure(1'b0, 1'b1, 16'd5);
        random_phase(80);

        // Zero cap: every new device starts a fresh session.
        reconfigure(1'b1, 1'b0, 16'd0);
        random_phase(15);

        reconfigure(1'b1, 1'b1, 16'd1);
        back_to_back = 1'b1;
        random_phase(20);
        back_to_back = 1'b0;

        // Both kinds disabled: every sighting is dropped.
        reconfigure(1'b0, 1'b0, 16'd32768);
        random_phase(20);

        // Back to the reset settings; first half with no idle cycles at all.
        reconfigure(1'b1, 1'b1, CAP_RESET);
        back_to_back = 1'b1;
        random_phase(125);
        back_to_back = 1'b0;
        random_phase(125);
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        $display("checked %0d result beats over six register settings, %0d table rollovers",
                 checked, rollovers);
        if (fail_count == 0) begin
            $display("** mac_dedup_hash_table: PASSED **");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("** mac_dedup_hash_table: FAILED **");
        end
        $finish;
    end

endmodule
